// ===== src/ects_pkg.sv =====
// Package for the engine charger throttle sequencer.
// Holds widths, phase and register codes, shared structs and the command helper.
// No dependencies.
`timescale 1ns / 1ps

package ects_pkg;

  // Field widths.
  localparam int FRAC_BITS = 20;
  localparam int ADC_BITS  = 10;
  localparam int RPM_BITS  = 16;
  localparam int WARM_BITS = 16;
  localparam int SERVO_W   = 12;
  localparam int PHASE_W   = 3;
  localparam int MODE_W    = 2;
  localparam int OFS_W     = 9;

  // The command holds an integer part in [-256, 256) plus the fraction bits.
  localparam int CMD_W  = FRAC_BITS + OFS_W;
  localparam int PROD_W = ADC_BITS + FRAC_BITS;
  localparam int SUM_W  = ((CMD_W > PROD_W) ? CMD_W : PROD_W) + 2;

  // Configuration port widths.
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DW_A  = (FRAC_BITS > RPM_BITS) ? FRAC_BITS : RPM_BITS;
  localparam int CFG_DW_B  = (ADC_BITS > WARM_BITS) ? ADC_BITS : WARM_BITS;
  localparam int CFG_DW    = (CFG_DW_A > CFG_DW_B) ? CFG_DW_A : CFG_DW_B;

  // Servo compare values and command limits.
  localparam int SERVO_FULL         = 2775;
  localparam int SERVO_LOW          = 3020;
  localparam int THROTTLE_DOWN_STEP = 100;
  localparam int CMD_UPPER_INT      = 245;

  // Charger phases.
  localparam logic [PHASE_W-1:0] PH_OFF    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WARM   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DOWN   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CHARGE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FAULT  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DONE   = 3'd5;

  // Run modes.
  localparam logic [MODE_W-1:0] RUN_CHARGE = 2'd0;
  localparam logic [MODE_W-1:0] RUN_LOAD   = 2'd1;
  localparam logic [MODE_W-1:0] RUN_FULL   = 2'd2;
  localparam logic [MODE_W-1:0] RUN_SPARE  = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_POINT     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_GAIN     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_TICKS  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ON_RPM    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR_RPM   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHG_RPM   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_LIMIT = 4'd7;

  typedef struct packed {
    logic [MODE_W-1:0]    run_mode;
    logic [ADC_BITS-1:0]  set_point;
    logic [FRAC_BITS-1:0] loop_gain;
    logic [WARM_BITS-1:0] warmup_ticks;
    logic [RPM_BITS-1:0]  min_on_rpm;
    logic [RPM_BITS-1:0]  low_throttle_rpm;
    logic [RPM_BITS-1:0]  min_charging_rpm;
    logic [ADC_BITS-1:0]  voltage_limit;
  } cfg_t;

  typedef struct packed {
    logic [RPM_BITS-1:0] rpm;
    logic [ADC_BITS-1:0] current;
    logic [ADC_BITS-1:0] voltage;
    logic                interlock_ok;
  } tick_t;

  typedef struct packed {
    logic [PHASE_W-1:0]     phase;
    logic [SERVO_W-1:0]     servo;
    logic signed [CMD_W-1:0] cmd;
  } result_t;

  // Integer part of the command, truncated toward zero.
  function automatic logic signed [OFS_W-1:0] cmd_int_part(input logic signed [CMD_W-1:0] c);
    logic [CMD_W-1:0] mag;
    logic [OFS_W-1:0] ipm;
    mag = c[CMD_W-1] ? CMD_W'(-c) : CMD_W'(c);
    ipm = mag[CMD_W-1:FRAC_BITS];
    return c[CMD_W-1] ? OFS_W'(-ipm) : ipm;
  endfunction

endpackage

// ===== src/engine_charger_throttle_sequencer.sv =====
// Top level of the engine charger throttle sequencer.
// Depends on ects_pkg, ects_cfg_regs and ects_tick.
`timescale 1ns / 1ps

// One input beat is one control tick and gives exactly one result beat. The
// block takes one beat per clock cycle while in_stall_o is low; a result beat
// is presented from the result register once its tick has passed the input
// register. The tick waits in the input register while the sequencer state is
// updated, and the outcome then sits in the result register. A stall on the
// result side backs up into the input register and then into the input stall.
// Configuration writes are taken in every cycle and should be made only while
// no tick is in flight.
module engine_charger_throttle_sequencer
  import ects_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Tick input channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [RPM_BITS-1:0]     engine_rpm_i,
  input  logic [ADC_BITS-1:0]     current_avg_i,
  input  logic [ADC_BITS-1:0]     voltage_avg_i,
  input  logic                    interlock_ok_i,
  // Result channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PHASE_W-1:0]      charger_phase_o,
  output logic [SERVO_W-1:0]      servo_compare_o,
  output logic                    contactor_closed_o,
  output logic                    discharge_on_o,
  output logic signed [OFS_W-1:0] throttle_offset_o,
  // Configuration write channel.
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DW-1:0]       cfg_data_i
);

  cfg_t    cfg;
  tick_t   tick_q;
  result_t result, result_q;
  logic    in_valid_q, out_valid_q;
  logic    in_accept, fire;

  ects_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: process when the result register is free or being drained.
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_accept || (in_valid_q && !fire);
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tick_q.rpm          <= engine_rpm_i;
      tick_q.current      <= current_avg_i;
      tick_q.voltage      <= voltage_avg_i;
      tick_q.interlock_ok <= interlock_ok_i;
    end
  end

  ects_tick u_tick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .tick_i   (tick_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign charger_phase_o    = result_q.phase;
  assign servo_compare_o    = result_q.servo;
  assign contactor_closed_o = (result_q.phase == PH_CHARGE);
  assign discharge_on_o     = (result_q.phase == PH_CHARGE);
  assign throttle_offset_o  = cmd_int_part(result_q.cmd);

endmodule

// ===== src/ects_cfg_regs.sv =====
// Configuration register file of the engine charger throttle sequencer.
// Depends on ects_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module ects_cfg_regs
  import ects_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Decode the register index; other indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RUN_MODE:      cfg_d.run_mode         = cfg_data_i[MODE_W-1:0];
        REG_SET_POINT:     cfg_d.set_point        = cfg_data_i[ADC_BITS-1:0];
        REG_LOOP_GAIN:     cfg_d.loop_gain        = cfg_data_i[FRAC_BITS-1:0];
        REG_WARMUP_TICKS:  cfg_d.warmup_ticks     = cfg_data_i[WARM_BITS-1:0];
        REG_MIN_ON_RPM:    cfg_d.min_on_rpm       = cfg_data_i[RPM_BITS-1:0];
        REG_LOW_THR_RPM:   cfg_d.low_throttle_rpm = cfg_data_i[RPM_BITS-1:0];
        REG_MIN_CHG_RPM:   cfg_d.min_charging_rpm = cfg_data_i[RPM_BITS-1:0];
        REG_VOLTAGE_LIMIT: cfg_d.voltage_limit    = cfg_data_i[ADC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register storage with the documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_mode         <= RUN_CHARGE;
      cfg_q.set_point        <= ADC_BITS'(50);
      cfg_q.loop_gain        <= FRAC_BITS'(1049);
      cfg_q.warmup_ticks     <= WARM_BITS'(2000);
      cfg_q.min_on_rpm       <= RPM_BITS'(10);
      cfg_q.low_throttle_rpm <= RPM_BITS'(200);
      cfg_q.min_charging_rpm <= RPM_BITS'(600);
      cfg_q.voltage_limit    <= ADC_BITS'(500);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/ects_tick.sv =====
// Per-tick sequencer state and update logic of the engine charger throttle sequencer.
// Depends on ects_pkg for phase codes, widths, structs and cmd_int_part.
`timescale 1ns / 1ps

module ects_tick
  import ects_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  tick_t   tick_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam logic signed [CMD_W-1:0] CMD_UPPER = CMD_W'(CMD_UPPER_INT) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] CMD_MAX   = SUM_W'({1'b0, {(CMD_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] CMD_MIN   = -(SUM_W'(1) <<< (CMD_W-1));

  logic [PHASE_W-1:0]      phase_q, phase_d, phase_ovr;
  logic signed [CMD_W-1:0] cmd_q, cmd_d;
  logic [WARM_BITS-1:0]    warm_q, warm_d, warm_inc;
  logic [SERVO_W-1:0]      servo_q, servo_d;

  logic                    cycle_run, full_test, below_on;
  logic                    cur_lt, cur_gt, cmd_up, cmd_dn;
  logic [ADC_BITS-1:0]     diff;
  logic [PROD_W-1:0]       prod;
  logic signed [SUM_W-1:0] sum_raw;
  logic signed [CMD_W-1:0] cmd_reg;
  logic signed [OFS_W-1:0] ip_now;

  // Mode decode and overrides from the interlock and the voltage limit.
  always_comb begin
    cycle_run = cfg_i.run_mode inside {RUN_CHARGE, RUN_SPARE};
    full_test = (cfg_i.run_mode == RUN_FULL);
    below_on  = (tick_i.rpm < cfg_i.min_on_rpm);
    phase_ovr = phase_q;
    if (!tick_i.interlock_ok) phase_ovr = PH_FAULT;
    if (cycle_run && (tick_i.voltage >= cfg_i.voltage_limit)) phase_ovr = PH_DONE;
  end

  // Proportional-integrating command step, one shared multiplier.
  always_comb begin
    cur_lt  = (tick_i.current < cfg_i.set_point);
    cur_gt  = (tick_i.current > cfg_i.set_point);
    diff    = cur_lt ? (cfg_i.set_point - tick_i.current) : (tick_i.current - cfg_i.set_point);
    prod    = PROD_W'(diff) * PROD_W'(cfg_i.loop_gain);
    cmd_up  = (cmd_q <= CMD_UPPER) && cur_lt;
    cmd_dn  = !cmd_up && !cmd_q[CMD_W-1] && cur_gt && (tick_i.rpm > cfg_i.min_charging_rpm);
    sum_raw = SUM_W'(cmd_q);
    if (cmd_up) begin
      sum_raw = SUM_W'(cmd_q) + $signed(SUM_W'(prod));
    end else if (cmd_dn) begin
      sum_raw = SUM_W'(cmd_q) - $signed(SUM_W'(prod));
    end
    if (sum_raw > CMD_MAX) begin
      cmd_reg = CMD_MAX[CMD_W-1:0];
    end else if (sum_raw < CMD_MIN) begin
      cmd_reg = CMD_MIN[CMD_W-1:0];
    end else begin
      cmd_reg = sum_raw[CMD_W-1:0];
    end
  end

  assign ip_now   = cmd_int_part(cmd_q);
  assign warm_inc = (warm_q == {WARM_BITS{1'b1}}) ? warm_q : warm_q + 1'b1;

  // Phase actions.
  always_comb begin
    phase_d = phase_ovr;
    cmd_d   = cmd_q;
    warm_d  = warm_q;
    servo_d = servo_q;
    case (phase_ovr)
      PH_OFF: begin
        servo_d = SERVO_W'(SERVO_FULL);
        warm_d  = '0;
        cmd_d   = '0;
        if (!below_on) phase_d = PH_WARM;
      end
      PH_WARM: begin
        if (below_on) phase_d = PH_OFF;
        servo_d = SERVO_W'(SERVO_FULL);
        warm_d  = warm_inc;
        if (warm_inc >= cfg_i.warmup_ticks) phase_d = PH_DOWN;
      end
      PH_DOWN: begin
        if (below_on) phase_d = PH_OFF;
        if (tick_i.rpm < cfg_i.low_throttle_rpm) phase_d = PH_CHARGE;
        servo_d = SERVO_W'(SERVO_LOW - THROTTLE_DOWN_STEP);
      end
      PH_CHARGE: begin
        if (below_on) phase_d = PH_OFF;
        if (full_test) begin
          servo_d = SERVO_W'(SERVO_FULL);
        end else begin
          servo_d = SERVO_W'(SERVO_LOW) - SERVO_W'(ip_now);
          cmd_d   = cmd_reg;
        end
      end
      default: ;
    endcase
  end

  // Sequencer state, advanced once per processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OFF;
      cmd_q   <= '0;
      warm_q  <= '0;
      servo_q <= SERVO_W'(SERVO_FULL);
    end else if (fire_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      warm_q  <= warm_d;
      servo_q <= servo_d;
    end
  end

  assign result_o.phase = phase_d;
  assign result_o.servo = servo_d;
  assign result_o.cmd   = cmd_d;

endmodule

// ===== src/ects_checker.sv =====
// Port-level checker for the engine charger throttle sequencer, with its bind.
// Depends on ects_pkg for the phase codes and widths.
`timescale 1ns / 1ps

module ects_checker
  import ects_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [PHASE_W-1:0]      charger_phase_o,
  input logic [SERVO_W-1:0]      servo_compare_o,
  input logic                    contactor_closed_o,
  input logic                    discharge_on_o,
  input logic signed [OFS_W-1:0] throttle_offset_o
);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(charger_phase_o)
      && $stable(servo_compare_o) && $stable(throttle_offset_o))
    else $error("stalled result beat changed");

  // The input side only stalls behind a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with the result register empty");

  // Contactor and discharge follow the charging phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (contactor_closed_o == (charger_phase_o == PH_CHARGE))
      && (discharge_on_o == contactor_closed_o))
    else $error("contactor or discharge disagrees with the phase");

  // Warming always runs at full throttle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (charger_phase_o == PH_WARM) |-> servo_compare_o == SERVO_W'(SERVO_FULL))
    else $error("servo not at full throttle while warming");

  // The bounded command keeps the servo value in its window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (servo_compare_o >= SERVO_W'(SERVO_LOW - 255))
      && (servo_compare_o <= SERVO_W'(SERVO_LOW + 256)))
    else $error("servo compare value out of range");

endmodule

bind engine_charger_throttle_sequencer ects_checker u_ects_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .charger_phase_o    (charger_phase_o),
  .servo_compare_o    (servo_compare_o),
  .contactor_closed_o (contactor_closed_o),
  .discharge_on_o     (discharge_on_o),
  .throttle_offset_o  (throttle_offset_o)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the engine charger throttle sequencer.
// Depends on ects_pkg and engine_charger_throttle_sequencer; predicts each tick
// in place and compares every result beat field by field.
`timescale 1ns / 1ps

module tb_top;
  import ects_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

  // One result beat as the sequencer should report it.
  typedef struct packed {
    logic [PHASE_W-1:0]     phase;
    logic [SERVO_W-1:0]     servo;
    logic                   contactor;
    logic                   discharge;
    logic signed [OFS_W-1:0] offset;
  } outcome_t;

  typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_e;

  // One line of the stimulus table: a tick or a register write.
  typedef struct {
    row_kind_e             kind;
    tick_t                 tick;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DW-1:0]     data;
    bit                    typed;
    outcome_t              want;
  } row_t;

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [RPM_BITS-1:0]     engine_rpm_i = '0;
  logic [ADC_BITS-1:0]     current_avg_i = '0;
  logic [ADC_BITS-1:0]     voltage_avg_i = '0;
  logic                    interlock_ok_i = 1'b1;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [PHASE_W-1:0]      charger_phase_o;
  logic [SERVO_W-1:0]      servo_compare_o;
  logic                    contactor_closed_o;
  logic                    discharge_on_o;
  logic signed [OFS_W-1:0] throttle_offset_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DW-1:0]       cfg_data_i = '0;

  engine_charger_throttle_sequencer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .engine_rpm_i       (engine_rpm_i),
    .current_avg_i      (current_avg_i),
    .voltage_avg_i      (voltage_avg_i),
    .interlock_ok_i     (interlock_ok_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .charger_phase_o    (charger_phase_o),
    .servo_compare_o    (servo_compare_o),
    .contactor_closed_o (contactor_closed_o),
    .discharge_on_o     (discharge_on_o),
    .throttle_offset_o  (throttle_offset_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  // Shadow copy of the registers, starting at their reset values.
  logic [MODE_W-1:0]    set_mode     = RUN_CHARGE;
  logic [ADC_BITS-1:0]  set_current  = ADC_BITS'(50);
  logic [FRAC_BITS-1:0] set_gain     = FRAC_BITS'(1049);
  logic [WARM_BITS-1:0] set_warmup   = WARM_BITS'(2000);
  logic [RPM_BITS-1:0]  set_on_rpm   = RPM_BITS'(10);
  logic [RPM_BITS-1:0]  set_low_rpm  = RPM_BITS'(200);
  logic [RPM_BITS-1:0]  set_chg_rpm  = RPM_BITS'(600);
  logic [ADC_BITS-1:0]  set_volt_lim = ADC_BITS'(500);

  // Shadow sequencer state.
  logic [PHASE_W-1:0] sim_phase = PH_OFF;
  longint             sim_cmd   = 0;
  int unsigned        sim_warm  = 0;
  logic [SERVO_W-1:0] sim_servo = SERVO_W'(SERVO_FULL);

  outcome_t tick_outcomes[$];
  int       bad_fields = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Whole part of the command, truncated toward zero.
  function automatic longint whole_part(input longint c);
    if (c < 0) return -((-c) >> FRAC_BITS);
    return c >> FRAC_BITS;
  endfunction

  // Proportional-integrating update of the throttle command, bounded.
  function automatic void regulate_throttle(input longint rpm, input longint cur);
    longint upper, hi, lo, sp, gain;
    upper = longint'(CMD_UPPER_INT) << FRAC_BITS;
    hi    = (longint'(256) << FRAC_BITS) - 1;
    lo    = -(longint'(256) << FRAC_BITS);
    sp    = longint'(set_current);
    gain  = longint'(set_gain);
    if (sim_cmd <= upper && cur < sp) begin
      sim_cmd = sim_cmd + (sp - cur) * gain;
    end else if (sim_cmd >= 0 && cur > sp && rpm > longint'(set_chg_rpm)) begin
      sim_cmd = sim_cmd - (cur - sp) * gain;
    end
    if (sim_cmd > hi) sim_cmd = hi;
    if (sim_cmd < lo) sim_cmd = lo;
  endfunction

  // Advance the shadow sequencer by one tick and report its outputs.
  function automatic outcome_t advance_charger(input tick_t t);
    outcome_t o;
    bit full_test, cycle_run;
    full_test = (set_mode == RUN_FULL);
    cycle_run = (set_mode == RUN_CHARGE || set_mode == RUN_SPARE);
    if (!t.interlock_ok) sim_phase = PH_FAULT;
    if (cycle_run && t.voltage >= set_volt_lim) sim_phase = PH_DONE;
    case (sim_phase)
      PH_OFF: begin
        sim_servo = SERVO_W'(SERVO_FULL);
        sim_warm  = 0;
        sim_cmd   = 0;
        if (t.rpm >= set_on_rpm) sim_phase = PH_WARM;
      end
      PH_WARM: begin
        if (t.rpm < set_on_rpm) sim_phase = PH_OFF;
        sim_servo = SERVO_W'(SERVO_FULL);
        if (sim_warm < 32'hFFFF) sim_warm++;
        if (sim_warm >= set_warmup) sim_phase = PH_DOWN;
      end
      PH_DOWN: begin
        if (t.rpm < set_on_rpm) sim_phase = PH_OFF;
        if (t.rpm < set_low_rpm) sim_phase = PH_CHARGE;
        sim_servo = SERVO_W'(SERVO_LOW - THROTTLE_DOWN_STEP);
      end
      PH_CHARGE: begin
        if (t.rpm < set_on_rpm) sim_phase = PH_OFF;
        if (full_test) begin
          sim_servo = SERVO_W'(SERVO_FULL);
        end else begin
          // The servo follows the command as it stood before this update.
          sim_servo = SERVO_W'(longint'(SERVO_LOW) - whole_part(sim_cmd));
          regulate_throttle(longint'(t.rpm), longint'(t.current));
        end
      end
      default: ;
    endcase
    o.phase     = sim_phase;
    o.servo     = sim_servo;
    o.contactor = (sim_phase == PH_CHARGE);
    o.discharge = (sim_phase == PH_CHARGE);
    o.offset    = OFS_W'(whole_part(sim_cmd));
    return o;
  endfunction

  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DW-1:0] data);
    case (idx)
      REG_RUN_MODE:      set_mode     = data[MODE_W-1:0];
      REG_SET_POINT:     set_current  = data[ADC_BITS-1:0];
      REG_LOOP_GAIN:     set_gain     = data[FRAC_BITS-1:0];
      REG_WARMUP_TICKS:  set_warmup   = data[WARM_BITS-1:0];
      REG_MIN_ON_RPM:    set_on_rpm   = data[RPM_BITS-1:0];
      REG_LOW_THR_RPM:   set_low_rpm  = data[RPM_BITS-1:0];
      REG_MIN_CHG_RPM:   set_chg_rpm  = data[RPM_BITS-1:0];
      REG_VOLTAGE_LIMIT: set_volt_lim = data[ADC_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Table rows.
  function automatic row_t tick_row(input int rpm, input int cur, input int volt, input bit ilk);
    row_t r;
    r.kind = ROW_TICK;
    r.tick.rpm = rpm[RPM_BITS-1:0];
    r.tick.current = cur[ADC_BITS-1:0];
    r.tick.voltage = volt[ADC_BITS-1:0];
    r.tick.interlock_ok = ilk;
    r.idx = '0;
    r.data = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t typed_row(input int rpm, input int cur, input int volt, input bit ilk,
                                     input logic [PHASE_W-1:0] ph, input int servo,
                                     input int ofs);
    row_t r;
    r = tick_row(rpm, cur, volt, ilk);
    r.typed = 1'b1;
    r.want.phase = ph;
    r.want.servo = servo[SERVO_W-1:0];
    r.want.contactor = (ph == PH_CHARGE);
    r.want.discharge = (ph == PH_CHARGE);
    r.want.offset = ofs[OFS_W-1:0];
    return r;
  endfunction

  function automatic row_t write_row(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    row_t r;
    r = tick_row(0, 0, 0, 1'b1);
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data[CFG_DW-1:0];
    return r;
  endfunction

  // Mostly a typical value, now and then one end of the range.
  function automatic int unsigned pick_extreme(input int unsigned hi, input int unsigned typical);
    int unsigned r;
    r = $urandom_range(15, 0);
    if (r == 0) return 0;
    if (r == 1) return hi;
    return typical;
  endfunction

  // Drive one tick beat, with random idle cycles in front of it.
  task automatic send_tick(input tick_t t, input bit typed, input outcome_t want);
    outcome_t predicted;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    engine_rpm_i   = t.rpm;
    current_avg_i  = t.current;
    voltage_avg_i  = t.voltage;
    interlock_ok_i = t.interlock_ok;
    do @(posedge clk_i); while (in_stall_o);
    predicted = advance_charger(t);
    tick_outcomes.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Register write, made only once every tick in flight has come out.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    in_valid_i = 1'b0;
    do @(negedge clk_i); while (tick_outcomes.size() != 0);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data[CFG_DW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_setting(idx, data[CFG_DW-1:0]);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_rows(input row_t rows[$]);
    for (int i = 0; i < rows.size(); i++) begin
      if (rows[i].kind == ROW_WRITE) write_reg(rows[i].idx, rows[i].data);
      else send_tick(rows[i].tick, rows[i].typed, rows[i].want);
    end
  endtask

  // New register settings that still let the sequence get to charging.
  task automatic write_random_settings();
    int unsigned mode, low;
    mode = $urandom_range(3, 0);
    write_reg(REG_RUN_MODE, mode);
    write_reg(REG_SET_POINT, pick_extreme(1023, $urandom_range(1023, 0)));
    write_reg(REG_LOOP_GAIN, pick_extreme(1048575, $urandom_range(1, 0) ?
                             $urandom_range(1048575, 0) : $urandom_range(65535, 0)));
    write_reg(REG_WARMUP_TICKS, pick_extreme(65535, $urandom_range(6, 1)));
    write_reg(REG_MIN_ON_RPM, pick_extreme(65535, $urandom_range(300, 0)));
    low = int'(set_on_rpm) + $urandom_range(2000, 1);
    if (low > 65535) low = 65535;
    write_reg(REG_LOW_THR_RPM, pick_extreme(65535, low));
    write_reg(REG_MIN_CHG_RPM, pick_extreme(65535, $urandom_range(5000, 0)));
    // In a charge cycle a reachable voltage limit would end the run for good.
    if (set_mode == RUN_CHARGE || set_mode == RUN_SPARE) begin
      write_reg(REG_VOLTAGE_LIMIT, ($urandom_range(7, 0) == 0) ? 1023 : $urandom_range(1023, 512));
    end else begin
      write_reg(REG_VOLTAGE_LIMIT, pick_extreme(1023, $urandom_range(1023, 0)));
    end
    if ($urandom_range(3, 0) == 0) write_reg(REG_UNUSED, $urandom_range(1048575, 0));
  endtask

  // Well-formed tick for the current phase, with some noise on the speed.
  function automatic tick_t steer_tick();
    tick_t t;
    int c, on, hi;
    on = int'(set_on_rpm);
    t.interlock_ok = 1'b1;
    if ($urandom_range(1, 0)) begin
      t.current = ADC_BITS'($urandom_range(1023, 0));
    end else begin
      c = int'(set_current) + int'($urandom_range(16, 0)) - 8;
      if (c < 0) c = 0;
      if (c > 1023) c = 1023;
      t.current = c[ADC_BITS-1:0];
    end
    if (set_mode == RUN_CHARGE || set_mode == RUN_SPARE) begin
      t.voltage = (set_volt_lim == 0) ? '0
                                      : ADC_BITS'($urandom_range(int'(set_volt_lim) - 1, 0));
    end else begin
      t.voltage = ADC_BITS'($urandom_range(1023, 0));
    end
    if ($urandom_range(9, 0) == 0) begin
      t.rpm = RPM_BITS'($urandom_range(65535, 0));
    end else begin
      case (sim_phase)
        PH_DOWN: begin
          if (int'(set_low_rpm) > on) t.rpm = RPM_BITS'($urandom_range(int'(set_low_rpm) - 1, on));
          else t.rpm = RPM_BITS'($urandom_range(65535, on));
        end
        PH_CHARGE: begin
          hi = 2 * int'(set_chg_rpm) + 100;
          if (hi > 65535) hi = 65535;
          if (hi < on) hi = on;
          t.rpm = RPM_BITS'($urandom_range(hi, on));
        end
        default: t.rpm = RPM_BITS'($urandom_range(65535, on));
      endcase
    end
    return t;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      bad_fields++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Result side: random stall, and every beat against the oldest prediction.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tick_outcomes.size() == 0) begin
        bad_fields++;
        $display("%0t: result beat with no tick waiting for it", $time);
      end else begin
        want = tick_outcomes.pop_front();
        check_field("charger_phase", want.phase, charger_phase_o);
        check_field("servo_compare", want.servo, servo_compare_o);
        check_field("contactor_closed", want.contactor, contactor_closed_o);
        check_field("discharge_on", want.discharge, discharge_on_o);
        check_field("throttle_offset", want.offset, throttle_offset_o);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    row_t directed[$];
    row_t closing[$];
    int   send_pct[3];
    int   recv_pct[3];
    send_pct = '{13, 60, 0};
    recv_pct = '{60, 13, 0};

    // Directed table: reset values first, then each end of the command range.
    directed.push_back(typed_row(0, 0, 0, 1'b1, PH_OFF, SERVO_FULL, 0));
    directed.push_back(typed_row(9, 0, 0, 1'b1, PH_OFF, SERVO_FULL, 0));
    // Zero warm-up ticks: warming leaves on its first tick.
    directed.push_back(write_row(REG_WARMUP_TICKS, 0));
    directed.push_back(typed_row(65535, 1023, 499, 1'b1, PH_WARM, SERVO_FULL, 0));
    directed.push_back(typed_row(100, 50, 0, 1'b1, PH_DOWN, SERVO_FULL, 0));
    directed.push_back(typed_row(150, 50, 0, 1'b1, PH_CHARGE, SERVO_LOW - THROTTLE_DOWN_STEP, 0));
    directed.push_back(typed_row(300, 0, 0, 1'b1, PH_CHARGE, SERVO_LOW, 0));
    // Full gain and set point drive the command into its upper bound.
    directed.push_back(write_row(REG_LOOP_GAIN, 1048575));
    directed.push_back(write_row(REG_SET_POINT, 1023));
    directed.push_back(typed_row(300, 0, 0, 1'b1, PH_CHARGE, SERVO_LOW, 255));
    directed.push_back(typed_row(300, 0, 0, 1'b1, PH_CHARGE, SERVO_LOW - 255, 255));
    // Zero set point with full current drives it into the lower bound.
    directed.push_back(write_row(REG_SET_POINT, 0));
    directed.push_back(typed_row(601, 1023, 0, 1'b1, PH_CHARGE, SERVO_LOW - 255, -256));
    directed.push_back(typed_row(601, 1023, 0, 1'b1, PH_CHARGE, SERVO_LOW + 256, -256));
    directed.push_back(tick_row(600, 0, 499, 1'b1));
    directed.push_back(write_row(REG_SET_POINT, 50));
    directed.push_back(write_row(REG_LOOP_GAIN, 1049));
    directed.push_back(write_row(REG_RUN_MODE, RUN_FULL));
    directed.push_back(tick_row(700, 10, 1023, 1'b1));
    // The spare run mode behaves as a charge cycle.
    directed.push_back(write_row(REG_RUN_MODE, RUN_SPARE));
    directed.push_back(tick_row(700, 0, 499, 1'b1));
    directed.push_back(tick_row(5, 60, 0, 1'b1));
    directed.push_back(typed_row(0, 0, 0, 1'b1, PH_OFF, SERVO_FULL, 0));
    directed.push_back(write_row(REG_WARMUP_TICKS, 65535));
    directed.push_back(write_row(REG_UNUSED, 1048575));
    directed.push_back(typed_row(10, 1023, 499, 1'b1, PH_WARM, SERVO_FULL, 0));
    directed.push_back(typed_row(10, 0, 0, 1'b1, PH_WARM, SERVO_FULL, 0));
    directed.push_back(typed_row(9, 0, 0, 1'b1, PH_OFF, SERVO_FULL, 0));
    directed.push_back(write_row(REG_WARMUP_TICKS, 1));
    directed.push_back(write_row(REG_RUN_MODE, RUN_LOAD));
    directed.push_back(typed_row(1000, 0, 0, 1'b1, PH_WARM, SERVO_FULL, 0));
    directed.push_back(typed_row(1000, 0, 0, 1'b1, PH_DOWN, SERVO_FULL, 0));
    directed.push_back(typed_row(1000, 0, 0, 1'b1, PH_DOWN, SERVO_LOW - THROTTLE_DOWN_STEP, 0));
    // Below both limits, charging wins over off.
    directed.push_back(typed_row(5, 0, 0, 1'b1, PH_CHARGE, SERVO_LOW - THROTTLE_DOWN_STEP, 0));
    directed.push_back(tick_row(65535, 1023, 1023, 1'b1));

    // Reset held low from time zero, released on a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    run_rows(directed);

    // Random part: four register settings under each idling profile.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      for (int seg = 0; seg < 4; seg++) begin
        write_random_settings();
        repeat (50) send_tick(steer_tick(), 1'b0, '0);
      end
    end

    // Fault and complete are sticky, so they close the run.
    closing.push_back(write_row(REG_RUN_MODE, RUN_CHARGE));
    closing.push_back(write_row(REG_VOLTAGE_LIMIT, 1023));
    closing.push_back(tick_row($urandom_range(65535, 0), $urandom_range(1023, 0), 1022, 1'b1));
    closing.push_back(tick_row($urandom_range(65535, 0), $urandom_range(1023, 0), 0, 1'b0));
    closing.push_back(tick_row($urandom_range(65535, 0), $urandom_range(1023, 0), 0, 1'b1));
    // A complete charge replaces a fault.
    closing.push_back(tick_row($urandom_range(65535, 0), $urandom_range(1023, 0), 1023, 1'b1));
    closing.push_back(write_row(REG_VOLTAGE_LIMIT, 0));
    closing.push_back(write_row(REG_RUN_MODE, RUN_LOAD));
    repeat (6) begin
      closing.push_back(tick_row($urandom_range(65535, 0), $urandom_range(1023, 0),
                                 $urandom_range(1023, 0), 1'($urandom_range(1, 0))));
    end
    run_rows(closing);

    // Drain, then idle so that the block can show any stray beat.
    in_valid_i = 1'b0;
    while (tick_outcomes.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (bad_fields == 0 && tick_outcomes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
